FILE: hdl/hbfe_pkg.sv
package hbfe_pkg;

  // request codes
  localparam logic [1:0] REQ_LOAD_BATH   = 2'd0;
  localparam logic [1:0] REQ_LOAD_METHOD = 2'd1;
  localparam logic [1:0] REQ_FORCE       = 2'd2;
  localparam logic [1:0] REQ_ENERGY      = 2'd3;

  // result kinds
  localparam logic KIND_FORCE  = 1'b0;
  localparam logic KIND_ENERGY = 1'b1;

  localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;
  localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] RND_HALF = 64'sd32768;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         copy_index;
    logic [1:0]         bath_index;
    logic [1:0]         row_state;
    logic [1:0]         col_state;
    logic signed [31:0] element_value;
    logic signed [31:0] mode_frequency;
    logic signed [31:0] mode_coupling;
    logic signed [31:0] mode_position;
    logic               last_mode;
  } in_word_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] result_value;
    logic               saturated;
  } out_word_t;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } sat_t;

  // Q32.32 back to Q16.16, round half up
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + RND_HALF;
    return t >>> 16;
  endfunction

  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    if (v > SAT_HI) begin
      r.clip = 1'b1;
      r.val  = SAT_HI[31:0];
    end else if (v < SAT_LO) begin
      r.clip = 1'b1;
      r.val  = SAT_LO[31:0];
    end else begin
      r.clip = 1'b0;
      r.val  = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/harmonic_bath_force_engine.sv
// loads: taken back to back
// force: one shared 32x32 multiplier walks the matrix pairs through a
//   read/multiply/accumulate pipe
// energy term: result valid only when last_mode is set
// a finished result waits in the output register while the next word is taken
// reset (async, active low) clears control, accumulator and clip flags; stores are not cleared
module harmonic_bath_force_engine #(
  parameter int NUM_STATES = 4,
  parameter int NUM_BATHS  = 4,
  parameter int NUM_COPIES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hbfe_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hbfe_pkg::out_word_t out_word_o
);
  import hbfe_pkg::*;

  localparam int MAT        = NUM_STATES * NUM_STATES;
  localparam int BATH_DEPTH = NUM_BATHS * MAT;
  localparam int METH_DEPTH = NUM_COPIES * MAT;
  localparam int BA_W       = (BATH_DEPTH > 1) ? $clog2(BATH_DEPTH) : 1;
  localparam int MA_W       = (METH_DEPTH > 1) ? $clog2(METH_DEPTH) : 1;
  localparam int CNT_W      = $clog2(MAT + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_WSQ, S_HARM, S_HARMR, S_PAIR, S_PS, S_CP, S_FOUT,
    S_ERD, S_EMUL, S_ESC, S_EMUL2, S_EACC, S_EOUT
  } state_e;

  state_e             state_q, state_d;
  in_word_t           item_q, item_d;
  logic signed [31:0] wsq_q, wsq_d;
  logic signed [47:0] harm_q, harm_d;
  logic signed [63:0] pair_q, pair_d;
  logic signed [31:0] ps_q, ps_d;
  logic signed [31:0] sc_q, sc_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               rd_v_q, rd_v_d;
  logic               pv_q, pv_d;
  logic               fclip_q, fclip_d;
  logic signed [63:0] acc_q, acc_d;
  logic               eclip_q, eclip_d;
  out_word_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;

  // shared multiplier
  logic               mul_en;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_q;

  // stores
  logic signed [31:0] bath_mem [BATH_DEPTH];
  logic signed [31:0] meth_mem [METH_DEPTH];
  logic signed [31:0] s_rd_q, m_rd_q;
  logic [BA_W-1:0]    b_ra, b_wa, b_pair_ra, b_e_ra;
  logic [MA_W-1:0]    m_ra, m_wa;
  logic               b_we, m_we;

  logic               in_acc, in_rc_ok, e_ok, force_ok, out_free;
  logic signed [63:0] rnd_prod, force_raw, acc_sum;
  logic               acc_ovf;
  sat_t               sat_prod, sat_pair, sat_force, sat_acc;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // load addressing straight from the input word
  assign in_rc_ok = (int'(in_word_i.row_state) < NUM_STATES) &&
                    (int'(in_word_i.col_state) < NUM_STATES);
  assign b_wa = BA_W'(int'(in_word_i.bath_index) * MAT +
                      int'(in_word_i.row_state) * NUM_STATES + int'(in_word_i.col_state));
  assign m_wa = MA_W'(int'(in_word_i.copy_index) * MAT +
                      int'(in_word_i.row_state) * NUM_STATES + int'(in_word_i.col_state));
  assign b_we = in_acc && (in_word_i.req_type == REQ_LOAD_BATH) && in_rc_ok &&
                (int'(in_word_i.bath_index) < NUM_BATHS);
  assign m_we = in_acc && (in_word_i.req_type == REQ_LOAD_METHOD) && in_rc_ok &&
                (int'(in_word_i.copy_index) < NUM_COPIES);

  // addressing for the held request
  assign e_ok = (int'(item_q.bath_index) < NUM_BATHS) &&
                (int'(item_q.row_state) < NUM_STATES) &&
                (int'(item_q.col_state) < NUM_STATES);
  assign force_ok = (int'(item_q.bath_index) < NUM_BATHS) &&
                    (int'(item_q.copy_index) < NUM_COPIES);
  assign b_pair_ra = BA_W'(int'(item_q.bath_index) * MAT + int'(cnt_q));
  assign b_e_ra    = BA_W'(int'(item_q.bath_index) * MAT +
                           int'(item_q.row_state) * NUM_STATES + int'(item_q.col_state));
  assign m_ra      = MA_W'(int'(item_q.copy_index) * MAT + int'(cnt_q));
  assign b_ra      = (state_q == S_ERD) ? b_e_ra : b_pair_ra;

  // post-multiply arithmetic
  assign rnd_prod  = rnd16(prod_q);
  assign sat_prod  = sat32(rnd_prod);
  assign sat_pair  = sat32(pair_q);
  assign force_raw = -$signed({{16{harm_q[47]}}, harm_q}) - rnd_prod;
  assign sat_force = sat32(force_raw);
  assign sat_acc   = sat32(acc_q);
  assign acc_sum   = acc_q + rnd_prod;
  assign acc_ovf   = (acc_q[63] == rnd_prod[63]) && (acc_sum[63] != acc_q[63]);

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    wsq_d       = wsq_q;
    harm_d      = harm_q;
    pair_d      = pair_q;
    ps_d        = ps_q;
    sc_d        = sc_q;
    cnt_d       = cnt_q;
    rd_v_d      = rd_v_q;
    pv_d        = pv_q;
    fclip_d     = fclip_q;
    acc_d       = acc_q;
    eclip_d     = eclip_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_word_i;
          fclip_d = 1'b0;
          unique case (in_word_i.req_type) inside
            REQ_LOAD_BATH, REQ_LOAD_METHOD: ;
            REQ_FORCE:  state_d = S_SQ;
            REQ_ENERGY: state_d = S_ERD;
          endcase
        end
      end
      S_SQ: begin
        mul_en  = 1'b1;
        mul_a   = item_q.mode_frequency;
        mul_b   = item_q.mode_frequency;
        state_d = S_WSQ;
      end
      S_WSQ: begin
        wsq_d   = sat_prod.val;
        fclip_d = fclip_q | sat_prod.clip;
        state_d = S_HARM;
      end
      S_HARM: begin
        mul_en  = 1'b1;
        mul_a   = wsq_q;
        mul_b   = item_q.mode_position;
        state_d = S_HARMR;
      end
      S_HARMR: begin
        harm_d  = rnd_prod[47:0];
        cnt_d   = '0;
        rd_v_d  = 1'b0;
        pv_d    = 1'b0;
        pair_d  = '0;
        state_d = force_ok ? S_PAIR : S_PS;
      end
      S_PAIR: begin
        // issue read, multiply, accumulate: three words in flight
        if (cnt_q != CNT_W'(MAT)) begin
          cnt_d  = cnt_q + CNT_W'(1);
          rd_v_d = 1'b1;
        end else begin
          rd_v_d = 1'b0;
        end
        mul_en = 1'b1;
        mul_a  = s_rd_q;
        mul_b  = m_rd_q;
        pv_d   = rd_v_q;
        if (pv_q) begin
          pair_d = pair_q + rnd_prod;
        end
        if ((cnt_q == CNT_W'(MAT)) && !rd_v_q) begin
          state_d = S_PS;
        end
      end
      S_PS: begin
        ps_d    = sat_pair.val;
        fclip_d = fclip_q | sat_pair.clip;
        state_d = S_CP;
      end
      S_CP: begin
        mul_en  = 1'b1;
        mul_a   = item_q.mode_coupling;
        mul_b   = ps_q;
        state_d = S_FOUT;
      end
      S_FOUT: begin
        if (out_free) begin
          out_d.result_kind  = KIND_FORCE;
          out_d.result_value = sat_force.val;
          out_d.saturated    = fclip_q | sat_force.clip;
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      S_ERD: begin
        if (e_ok) begin
          state_d = S_EMUL;
        end else if (item_q.last_mode) begin
          state_d = S_EOUT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMUL: begin
        mul_en  = 1'b1;
        mul_a   = s_rd_q;
        mul_b   = item_q.mode_coupling;
        state_d = S_ESC;
      end
      S_ESC: begin
        sc_d    = sat_prod.val;
        eclip_d = eclip_q | sat_prod.clip;
        state_d = S_EMUL2;
      end
      S_EMUL2: begin
        mul_en  = 1'b1;
        mul_a   = sc_q;
        mul_b   = item_q.mode_position;
        state_d = S_EACC;
      end
      S_EACC: begin
        if (acc_ovf) begin
          acc_d   = rnd_prod[63] ? ACC_MIN : ACC_MAX;
          eclip_d = 1'b1;
        end else begin
          acc_d = acc_sum;
        end
        state_d = item_q.last_mode ? S_EOUT : S_IDLE;
      end
      S_EOUT: begin
        if (out_free) begin
          out_d.result_kind  = KIND_ENERGY;
          out_d.result_value = sat_acc.val;
          out_d.saturated    = eclip_q | sat_acc.clip;
          out_valid_d        = 1'b1;
          acc_d              = '0;
          eclip_d            = 1'b0;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '0;
      wsq_q       <= '0;
      harm_q      <= '0;
      pair_q      <= '0;
      ps_q        <= '0;
      sc_q        <= '0;
      cnt_q       <= '0;
      rd_v_q      <= 1'b0;
      pv_q        <= 1'b0;
      fclip_q     <= 1'b0;
      acc_q       <= '0;
      eclip_q     <= 1'b0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      wsq_q       <= wsq_d;
      harm_q      <= harm_d;
      pair_q      <= pair_d;
      ps_q        <= ps_d;
      sc_q        <= sc_d;
      cnt_q       <= cnt_d;
      rd_v_q      <= rd_v_d;
      pv_q        <= pv_d;
      fclip_q     <= fclip_d;
      acc_q       <= acc_d;
      eclip_q     <= eclip_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  // stores and multiplier datapath
  always_ff @(posedge clk_i) begin
    if (b_we) begin
      bath_mem[b_wa] <= in_word_i.element_value;
    end
    if (m_we) begin
      meth_mem[m_wa] <= in_word_i.element_value;
    end
    s_rd_q <= bath_mem[b_ra];
    m_rd_q <= meth_mem[m_ra];
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
  end

endmodule

FILE: hdl/hbfe_checker.sv
module hbfe_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input hbfe_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input hbfe_pkg::out_word_t out_word_o
);
  import hbfe_pkg::*;

  // a waiting result is held
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word dropped or changed while stalled");

  // loads never stall the input side
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o &&
    (in_word_i.req_type == REQ_LOAD_BATH || in_word_i.req_type == REQ_LOAD_METHOD)
    |=> in_ready_o)
    else $error("input not ready after a load");

  // a force request keeps the engine busy
  a_force_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_word_i.req_type == REQ_FORCE |=> !in_ready_o ##1 !in_ready_o)
    else $error("input ready too soon after a force request");

  // no result appears the cycle after a request is taken
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared one cycle after accept");

endmodule

bind harmonic_bath_force_engine hbfe_checker u_hbfe_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import hbfe_pkg::*;

  localparam int MAT_ELEMS   = 16;
  localparam int BATH_COUNT  = 4;
  localparam int COPY_COUNT  = 8;
  localparam int RANDOM_WORDS = 1300;
  localparam int IDLE_LIMIT  = 5000;
  localparam int TAIL_CYCLES = 40;

  class bath_result_board;
    logic signed [31:0] bath_mat [BATH_COUNT*MAT_ELEMS];
    logic signed [31:0] method_mat [COPY_COUNT*MAT_ELEMS];
    logic signed [63:0] energy_sum;
    bit                 energy_clip;
    out_word_t          pending_results [$];
    int                 errors;

    function new();
      energy_sum  = '0;
      energy_clip = 1'b0;
      errors      = 0;
    endfunction

    // floor((v + 2^15) / 2^16)
    function logic signed [63:0] round_q16(input logic signed [63:0] v);
      logic signed [63:0] t;
      t = v + 64'sd32768;
      return t >>> 16;
    endfunction

    function logic signed [63:0] clamp32(input logic signed [63:0] v, inout bit clip);
      if (v > SAT_HI) begin
        clip = 1'b1;
        return SAT_HI;
      end
      if (v < SAT_LO) begin
        clip = 1'b1;
        return SAT_LO;
      end
      return v;
    endfunction

    function out_word_t predict_force(input in_word_t w);
      logic signed [63:0] freq, coup, pos, wsq, harm, pair, ps, cp, f, s, m;
      bit clip;
      out_word_t r;
      int base_s, base_m;
      clip   = 1'b0;
      freq   = $signed(w.mode_frequency);
      coup   = $signed(w.mode_coupling);
      pos    = $signed(w.mode_position);
      wsq    = clamp32(round_q16(freq * freq), clip);
      harm   = round_q16(wsq * pos);
      pair   = '0;
      base_s = int'(w.bath_index) * MAT_ELEMS;
      base_m = int'(w.copy_index) * MAT_ELEMS;
      for (int k = 0; k < MAT_ELEMS; k++) begin
        s    = bath_mat[base_s + k];
        m    = method_mat[base_m + k];
        pair = pair + round_q16(s * m);
      end
      ps = clamp32(pair, clip);
      cp = round_q16(coup * ps);
      f  = clamp32(-harm - cp, clip);
      r.result_kind  = KIND_FORCE;
      r.result_value = f[31:0];
      r.saturated    = clip;
      return r;
    endfunction

    function void add_energy_term(input in_word_t w);
      logic signed [63:0] s, coup, pos, sc, term;
      int idx;
      idx  = int'(w.bath_index) * MAT_ELEMS + int'(w.row_state) * 4 + int'(w.col_state);
      s    = bath_mat[idx];
      coup = $signed(w.mode_coupling);
      pos  = $signed(w.mode_position);
      sc   = clamp32(round_q16(s * coup), energy_clip);
      term = round_q16(sc * pos);
      if (term > 0 && energy_sum > ACC_MAX - term) begin
        energy_sum  = ACC_MAX;
        energy_clip = 1'b1;
      end else if (term < 0 && energy_sum < ACC_MIN - term) begin
        energy_sum  = ACC_MIN;
        energy_clip = 1'b1;
      end else begin
        energy_sum = energy_sum + term;
      end
    endfunction

    function void note_input(input in_word_t w);
      int off;
      bit clip;
      logic signed [63:0] v;
      out_word_t r;
      off = int'(w.row_state) * 4 + int'(w.col_state);
      case (w.req_type)
        REQ_LOAD_BATH: begin
          bath_mat[int'(w.bath_index) * MAT_ELEMS + off] = w.element_value;
        end
        REQ_LOAD_METHOD: begin
          method_mat[int'(w.copy_index) * MAT_ELEMS + off] = w.element_value;
        end
        REQ_FORCE: begin
          r = predict_force(w);
          pending_results = {pending_results, r};
        end
        default: begin
          add_energy_term(w);
          if (w.last_mode) begin
            clip           = energy_clip;
            v              = clamp32(energy_sum, clip);
            r.result_kind  = KIND_ENERGY;
            r.result_value = v[31:0];
            r.saturated    = clip;
            pending_results = {pending_results, r};
            energy_sum  = '0;
            energy_clip = 1'b0;
          end
        end
      endcase
    endfunction

    task flag_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("%0t mismatch %0s: got %h want %h", $realtime, what, got, want);
    endtask

    task check_result(input out_word_t got);
      out_word_t want;
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected word", {31'd0, got.result_kind}, got.result_value);
        return;
      end
      want = pending_results.pop_front();
      if (got.result_kind !== want.result_kind)
        flag_mismatch("result_kind", {31'd0, got.result_kind}, {31'd0, want.result_kind});
      if (got.result_value !== want.result_value)
        flag_mismatch("result_value", got.result_value, want.result_value);
      if (got.saturated !== want.saturated)
        flag_mismatch("saturated", {31'd0, got.saturated}, {31'd0, want.saturated});
    endtask

    function int pending_count();
      return pending_results.size();
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_word_o;

  bath_result_board board;
  bit rush;
  int idle_cycles;

  harmonic_bath_force_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // sample both channels at the edge where the dut takes them
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        board.note_input(in_word_i);
      if (out_valid_o && out_ready_i)
        board.check_result(out_word_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT)
      @(posedge clk_i);
    $display("FAIL harmonic_bath_force_engine");
    $finish;
  end

  function automatic logic signed [31:0] pick_q16();
    logic signed [31:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'sh7FFF_FFFF;
      1: v = 32'sh8000_0000;
      2: v = '0;
      3, 4: v = $urandom;
      default: v = $urandom_range(0, 262143) - 131072;
    endcase
    return v;
  endfunction

  function automatic in_word_t make_word(input logic [1:0] req, input int copy, input int bath,
                                         input int row, input int col,
                                         input logic signed [31:0] elem,
                                         input logic signed [31:0] freq,
                                         input logic signed [31:0] coup,
                                         input logic signed [31:0] pos, input bit last);
    in_word_t w;
    w.req_type       = req;
    w.copy_index     = copy[2:0];
    w.bath_index     = bath[1:0];
    w.row_state      = row[1:0];
    w.col_state      = col[1:0];
    w.element_value  = elem;
    w.mode_frequency = freq;
    w.mode_coupling  = coup;
    w.mode_position  = pos;
    w.last_mode      = last;
    return w;
  endfunction

  function automatic in_word_t random_word(input logic [1:0] req);
    return make_word(req, $urandom_range(0, 7), $urandom_range(0, 3), $urandom_range(0, 3),
                     $urandom_range(0, 3), pick_q16(), pick_q16(), pick_q16(), pick_q16(),
                     $urandom_range(0, 1));
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    gap = rush ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // drop valid so the last word is not taken again while draining
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending_count() != 0) @(posedge clk_i);
  endtask

  // result side: draw a stall per word, then hold ready until one is taken
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = rush ? 0 : $urandom_range(0, 19);
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin
    logic signed [31:0] qmax, qmin, one;
    in_word_t w;
    int sent, len, pick;
    qmax = 32'sh7FFF_FFFF;
    qmin = 32'sh8000_0000;
    one  = 32'sh0001_0000;
    board       = new();
    rush        = 1'b0;
    idle_cycles = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    out_ready_i <= 1'b0;
    in_word_i   <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every matrix so no force or energy word reads an unwritten entry;
    // bath 3 and copy 7 are all full scale to drive the pair sum into clipping
    rush = 1'b1;
    for (int b = 0; b < BATH_COUNT; b++)
      for (int k = 0; k < MAT_ELEMS; k++)
        send_word(make_word(REQ_LOAD_BATH, $urandom_range(0, 7), b, k / 4, k % 4,
                            (b == 3) ? qmax : pick_q16(), pick_q16(), pick_q16(),
                            pick_q16(), $urandom_range(0, 1)));
    for (int c = 0; c < COPY_COUNT; c++)
      for (int k = 0; k < MAT_ELEMS; k++)
        send_word(make_word(REQ_LOAD_METHOD, c, $urandom_range(0, 3), k / 4, k % 4,
                            (c == 7) ? qmax : pick_q16(), pick_q16(), pick_q16(),
                            pick_q16(), $urandom_range(0, 1)));
    rush = 1'b0;

    // directed words
    send_word(make_word(REQ_LOAD_BATH, 0, 0, 0, 0, qmin, 0, 0, 0, 0));
    send_word(make_word(REQ_LOAD_METHOD, 0, 0, 0, 0, qmax, 0, 0, 0, 0));
    send_word(make_word(REQ_LOAD_METHOD, 7, 3, 3, 3, qmax, qmax, qmax, qmax, 1));
    send_word(make_word(REQ_FORCE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(REQ_FORCE, 0, 0, 0, 0, 0, qmax, 0, qmax, 0));
    send_word(make_word(REQ_FORCE, 0, 0, 0, 0, 0, qmin, qmin, qmin, 0));
    send_word(make_word(REQ_FORCE, 0, 0, 0, 0, 0, one, one, one, 0));
    send_word(make_word(REQ_FORCE, 7, 3, 0, 0, 0, one, qmax, one, 0));
    send_word(make_word(REQ_FORCE, 7, 3, 0, 0, 0, 32'sh0000_0100, qmin, 32'sh0000_8000, 1));
    send_word(make_word(REQ_FORCE, 5, 2, 1, 2, pick_q16(), 32'sh0001_8000,
                        32'shFFFF_4000, 32'sh0000_C000, 0));
    wait_drained();
    send_word(make_word(REQ_ENERGY, 0, 3, 0, 0, 0, 0, qmax, qmax, 1));
    send_word(make_word(REQ_ENERGY, 0, 3, 1, 1, 0, 0, qmin, qmax, 0));
    send_word(make_word(REQ_ENERGY, 0, 0, 0, 0, 0, 0, one, one, 0));
    send_word(make_word(REQ_ENERGY, 0, 1, 2, 3, 0, 0, one, 32'shFFFE_0000, 1));
    send_word(make_word(REQ_ENERGY, 0, 2, 3, 0, 0, 0, 0, qmax, 1));
    send_word(make_word(REQ_ENERGY, 0, 0, 0, 0, 0, 0, qmin, qmin, 1));
    send_word(make_word(REQ_ENERGY, 7, 3, 3, 3, qmax, qmax, 32'sh0000_8000, one, 1));
    wait_drained();

    // random words: mostly energy sums of a few terms, with forces and reloads between
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if (sent % 100 == 0)
        rush = ($urandom_range(0, 3) == 0);
      if (sent >= RANDOM_WORDS / 2 && sent < RANDOM_WORDS / 2 + 8)
        wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_word(random_word(REQ_LOAD_BATH));
        sent++;
      end else if (pick < 30) begin
        send_word(random_word(REQ_LOAD_METHOD));
        sent++;
      end else if (pick < 60) begin
        send_word(random_word(REQ_FORCE));
        sent++;
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          w = random_word(REQ_ENERGY);
          // a few broken sums end early or run on
          if ($urandom_range(0, 9) != 0)
            w.last_mode = (i == len - 1);
          send_word(w);
          sent++;
        end
      end
    end
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.errors == 0)
      $display("PASS harmonic_bath_force_engine");
    else
      $display("FAIL harmonic_bath_force_engine");
    $finish;
  end

endmodule
